// File: rtl/core/assert_macros.svh
// Concurrent assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General form: explicit clock and active-low reset.
`define XCC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Short form on the standard clock and reset names.
`define XCC_ASSERT_STD(lbl, prop) `XCC_ASSERT(lbl, clk_i, rst_ni, prop)

`endif

// File: rtl/core/xcc_pkg.sv
`default_nettype none

package xcc_pkg;

  typedef logic [31:0] word_t;
  typedef logic [15:0][31:0] state_t;
  typedef logic [7:0][31:0] subkey_t;

  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned DoubleRounds = 10;
  localparam int unsigned DrW = 4;
  localparam int unsigned PosW = 7;

  localparam logic [3:0][31:0] Sigma = {
    32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865
  };

  typedef enum logic [CfgIdxW-1:0] {
    CfgKey0,
    CfgKey1,
    CfgKey2,
    CfgKey3,
    CfgNonce0,
    CfgNonce1,
    CfgNonce2,
    CfgCounterStart
  } cfg_idx_e;

endpackage

`default_nettype wire

// File: rtl/core/xcc_ram.sv
`default_nettype none

module xcc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/core/xchacha20_stream_cipher_top.sv
`default_nettype none

// Channel  Direction  Handshake                Payload
// in       sink       in_valid_i / in_stall_o  data_byte_i, restart_i
// out      source     out_valid_o / out_stall_i result_byte_o
// cfg      sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A byte served from the keystream buffer passes through the Read and Out states to the result
// register; a new byte is taken only once the last one has left the Out state. A byte that finds
// the buffer empty first refills it: half quarter rounds on the shared unit, then the feed-forward
// into the buffer; a restart first runs the same rounds for the subkey and the Subkey state.
// Reset needs no clearing pass; the first transaction always restarts.
// A held result does not block acceptance of the next input byte, which then waits in Out.

module xchacha20_stream_cipher_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [7:0]                  data_byte_i,
  input  wire logic                        restart_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic      [7:0]                  result_byte_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [xcc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [63:0]                 cfg_data_i
);

  typedef enum logic [2:0] {
    StIdle,
    StRound,
    StSubkey,
    StFeed,
    StRead,
    StOut
  } state_e;

  state_e state_q, state_d;

  logic [3:0][63:0] key_q, key_d;
  logic [2:0][63:0] nonce_q, nonce_d;
  logic [63:0] ctr_start_q, ctr_start_d;

  xcc_pkg::subkey_t subkey_q, subkey_d;
  logic [63:0] counter_q, counter_d;
  logic [63:0] tail_q, tail_d;
  logic [xcc_pkg::PosW-1:0] pos_q, pos_d;
  logic setup_q, setup_d;
  logic hmode_q, hmode_d;

  xcc_pkg::state_t w_q, w_d;
  logic half_q, half_d;
  logic [1:0] qr_q, qr_d;
  logic phase_q, phase_d;
  logic [xcc_pkg::DrW-1:0] dr_q, dr_d;
  logic [3:0] feed_q, feed_d;

  logic [7:0] data_q, data_d;
  logic out_valid_q, out_valid_d;
  logic [7:0] result_q, result_d;

  xcc_pkg::state_t binit;
  xcc_pkg::state_t w_qr;
  xcc_pkg::state_t w_perm;
  xcc_pkg::word_t a1, b1, c1, d1, ax, cx;

  logic ram_we;
  logic [31:0] ram_wdata;
  logic [31:0] ram_rdata;
  logic in_acc;
  logic last_step;

  assign in_stall_o    = (state_q != StIdle);
  assign in_acc        = in_valid_i && (state_q == StIdle);
  assign cfg_ready_o   = 1'b1;
  assign out_valid_o   = out_valid_q;
  assign result_byte_o = result_q;

  assign binit = {tail_q, counter_q, subkey_q, xcc_pkg::Sigma};

  // half quarter round on column zero
  always_comb begin
    w_qr = w_q;
    a1 = w_q[0] + w_q[4];
    ax = w_q[12] ^ a1;
    d1 = half_q ? {ax[23:0], ax[31:24]} : {ax[15:0], ax[31:16]};
    c1 = w_q[8] + d1;
    cx = w_q[4] ^ c1;
    b1 = half_q ? {cx[24:0], cx[31:25]} : {cx[19:0], cx[31:20]};
    w_qr[0]  = a1;
    w_qr[4]  = b1;
    w_qr[8]  = c1;
    w_qr[12] = d1;
  end

  // rotate rows so the next quarter round lands on column zero
  always_comb begin
    logic [1:0] sft;
    logic [1:0] src;
    w_perm = w_qr;
    for (int r = 0; r < 4; r++) begin
      if (qr_q != 2'd3) begin
        sft = 2'd1;
      end else if (!phase_q) begin
        sft = 2'(r + 1);
      end else begin
        sft = 2'(1 - r);
      end
      for (int c = 0; c < 4; c++) begin
        src = 2'(c) + sft;
        w_perm[4 * r + c] = w_qr[4 * r + int'(src)];
      end
    end
  end

  assign last_step = half_q && phase_q && (qr_q == 2'd3) &&
                     (dr_q == xcc_pkg::DrW'(xcc_pkg::DoubleRounds - 1));

  assign ram_we    = (state_q == StFeed);
  assign ram_wdata = w_q[0] + binit[feed_q];

  always_comb begin
    state_d     = state_q;
    key_d       = key_q;
    nonce_d     = nonce_q;
    ctr_start_d = ctr_start_q;
    subkey_d    = subkey_q;
    counter_d   = counter_q;
    tail_d      = tail_q;
    pos_d       = pos_q;
    setup_d     = setup_q;
    hmode_d     = hmode_q;
    w_d         = w_q;
    half_d      = half_q;
    qr_d        = qr_q;
    phase_d     = phase_q;
    dr_d        = dr_q;
    feed_d      = feed_q;
    data_d      = data_q;
    out_valid_d = out_valid_q;
    result_d    = result_q;

    if (cfg_valid_i) begin
      case (cfg_index_i)
        xcc_pkg::CfgKey0:         key_d[0]    = cfg_data_i;
        xcc_pkg::CfgKey1:         key_d[1]    = cfg_data_i;
        xcc_pkg::CfgKey2:         key_d[2]    = cfg_data_i;
        xcc_pkg::CfgKey3:         key_d[3]    = cfg_data_i;
        xcc_pkg::CfgNonce0:       nonce_d[0]  = cfg_data_i;
        xcc_pkg::CfgNonce1:       nonce_d[1]  = cfg_data_i;
        xcc_pkg::CfgNonce2:       nonce_d[2]  = cfg_data_i;
        xcc_pkg::CfgCounterStart: ctr_start_d = cfg_data_i;
        default: ;
      endcase
    end

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          data_d  = data_byte_i;
          half_d  = 1'b0;
          qr_d    = 2'd0;
          phase_d = 1'b0;
          dr_d    = '0;
          feed_d  = '0;
          if (restart_i || !setup_q) begin
            w_d       = {nonce_q[1], nonce_q[0], key_q, xcc_pkg::Sigma};
            tail_d    = nonce_q[2];
            counter_d = ctr_start_q;
            pos_d     = {1'b1, {(xcc_pkg::PosW - 1){1'b0}}};
            setup_d   = 1'b1;
            hmode_d   = 1'b1;
            state_d   = StRound;
          end else if (pos_q[xcc_pkg::PosW-1]) begin
            w_d     = binit;
            hmode_d = 1'b0;
            state_d = StRound;
          end else begin
            state_d = StRead;
          end
        end
      end
      StRound: begin
        if (!half_q) begin
          w_d    = w_qr;
          half_d = 1'b1;
        end else begin
          w_d    = w_perm;
          half_d = 1'b0;
          qr_d   = qr_q + 2'd1;
          if (qr_q == 2'd3) begin
            phase_d = !phase_q;
            if (phase_q) begin
              dr_d = dr_q + 1'b1;
            end
          end
          if (last_step) begin
            dr_d    = '0;
            state_d = hmode_q ? StSubkey : StFeed;
          end
        end
      end
      StSubkey: begin
        subkey_d = {w_q[15:12], w_q[3:0]};
        w_d      = {tail_q, counter_q, w_q[15:12], w_q[3:0], xcc_pkg::Sigma};
        hmode_d  = 1'b0;
        state_d  = StRound;
      end
      StFeed: begin
        w_d    = {32'd0, w_q[15:1]};
        feed_d = feed_q + 4'd1;
        if (&feed_q) begin
          counter_d = counter_q + 64'd1;
          pos_d     = '0;
          state_d   = StRead;
        end
      end
      StRead: begin
        state_d = StOut;
      end
      StOut: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          result_d    = data_q ^ ram_rdata[8 * pos_q[1:0] +: 8];
          pos_d       = pos_q + 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      key_q       <= '0;
      nonce_q     <= '0;
      ctr_start_q <= '0;
      subkey_q    <= '0;
      counter_q   <= '0;
      tail_q      <= '0;
      pos_q       <= {1'b1, {(xcc_pkg::PosW - 1){1'b0}}};
      setup_q     <= 1'b0;
      hmode_q     <= 1'b0;
      w_q         <= '0;
      half_q      <= 1'b0;
      qr_q        <= 2'd0;
      phase_q     <= 1'b0;
      dr_q        <= '0;
      feed_q      <= '0;
      data_q      <= '0;
      out_valid_q <= 1'b0;
      result_q    <= '0;
    end else begin
      state_q     <= state_d;
      key_q       <= key_d;
      nonce_q     <= nonce_d;
      ctr_start_q <= ctr_start_d;
      subkey_q    <= subkey_d;
      counter_q   <= counter_d;
      tail_q      <= tail_d;
      pos_q       <= pos_d;
      setup_q     <= setup_d;
      hmode_q     <= hmode_d;
      w_q         <= w_d;
      half_q      <= half_d;
      qr_q        <= qr_d;
      phase_q     <= phase_d;
      dr_q        <= dr_d;
      feed_q      <= feed_d;
      data_q      <= data_d;
      out_valid_q <= out_valid_d;
      result_q    <= result_d;
    end
  end

  xcc_ram #(
    .Width(32),
    .Depth(16)
  ) u_ks_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(feed_q),
    .wdata_i(ram_wdata),
    .raddr_i(pos_q[5:2]),
    .rdata_o(ram_rdata)
  );

endmodule

`default_nettype wire

// File: rtl/core/xcc_checker.sv
`default_nettype none

`include "assert_macros.svh"

module xcc_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] result_byte_o
);

  logic [1:0] pending_q;
  logic in_acc;
  logic out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 2'd0;
    end else if (in_acc && !out_acc) begin
      pending_q <= pending_q + 2'd1;
    end else if (out_acc && !in_acc) begin
      pending_q <= pending_q - 2'd1;
    end
  end

  `XCC_ASSERT_STD(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(result_byte_o))
  `XCC_ASSERT_STD(a_one_in_flight, in_acc |=> in_stall_o)
  `XCC_ASSERT_STD(a_pending_bound, pending_q != 2'd3)
  `XCC_ASSERT_STD(a_no_orphan_out, out_valid_o |-> pending_q != 2'd0)

endmodule

bind xchacha20_stream_cipher_top xcc_checker u_xcc_checker (.*);

`default_nettype wire
